### rtl/core/pwbsd_pkg.sv
// Package for the pulse width bit slot decoder.
// Holds the configuration types, register indexes, reset values and slot timing tables.
// No dependencies.
`default_nettype none

package pwbsd_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned SlotWidth  = 14;

  localparam logic [TimeWidth-1:0] SlotOffset = 32'd500;
  localparam logic [TimeWidth-1:0] SlotLength = 32'd1000;
  localparam logic [IndexWidth-1:0] LastBit   = 3'd7;
  localparam logic [TimeWidth-1:0] LateLimit  = 32'd7000;

  localparam logic [CfgWidth-1:0] SyncLowReset  = 16'd470;
  localparam logic [CfgWidth-1:0] SyncHighReset = 16'd530;
  localparam logic [CfgWidth-1:0] GlitchReset   = 16'd100;
  localparam logic [CfgWidth-1:0] OneThrReset   = 16'd600;

  // Slot window bounds per bit index and slot base per timed slot.
  localparam logic [SlotWidth-1:0] SlotLo [8] = '{
    14'd500, 14'd1500, 14'd2500, 14'd3500, 14'd4500, 14'd5500, 14'd6500, 14'd7500
  };
  localparam logic [SlotWidth-1:0] SlotHi [8] = '{
    14'd1500, 14'd2500, 14'd3500, 14'd4500, 14'd5500, 14'd6500, 14'd7500, 14'd8500
  };
  localparam logic [SlotWidth-1:0] SlotBase [8] = '{
    14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000
  };

  typedef enum logic [1:0] {
    CfgSyncLow  = 2'd0,
    CfgSyncHigh = 2'd1,
    CfgGlitch   = 2'd2,
    CfgOneThr   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgWidth-1:0] sync_low;
    logic [CfgWidth-1:0] sync_high;
    logic [CfgWidth-1:0] glitch;
    logic [CfgWidth-1:0] one_thr;
  } cfg_t;

  typedef struct packed {
    logic                 emit;
    logic [ByteWidth-1:0] byte_value;
    logic                 buffer_slot;
  } dec_res_t;

endpackage

`default_nettype wire

### rtl/core/pwbsd_cfg_regs.sv
// Configuration register file for the pulse width bit slot decoder.
// Depends on pwbsd_pkg.
`default_nettype none

module pwbsd_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_addr_i,
  input  wire logic [pwbsd_pkg::CfgWidth-1:0]   cfg_wdata_i,
  output pwbsd_pkg::cfg_t                       cfg_o
);

  pwbsd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_low  <= pwbsd_pkg::SyncLowReset;
      cfg_q.sync_high <= pwbsd_pkg::SyncHighReset;
      cfg_q.glitch    <= pwbsd_pkg::GlitchReset;
      cfg_q.one_thr   <= pwbsd_pkg::OneThrReset;
    end else if (cfg_we_i) begin
      case (pwbsd_pkg::cfg_reg_e'(cfg_addr_i))
        pwbsd_pkg::CfgSyncLow:  cfg_q.sync_low  <= cfg_wdata_i;
        pwbsd_pkg::CfgSyncHigh: cfg_q.sync_high <= cfg_wdata_i;
        pwbsd_pkg::CfgGlitch:   cfg_q.glitch    <= cfg_wdata_i;
        pwbsd_pkg::CfgOneThr:   cfg_q.one_thr   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/pwbsd_decode.sv
// Framing state and per-edge decode logic for the pulse width bit slot decoder.
// Depends on pwbsd_pkg.
`default_nettype none

module pwbsd_decode (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  pwbsd_pkg::cfg_t                        cfg_i,
  input  wire logic                              step_i,
  input  wire logic                              line_level_i,
  input  wire logic [pwbsd_pkg::TimeWidth-1:0]   time_us_i,
  output pwbsd_pkg::dec_res_t                    res_o
);

  localparam int unsigned TW = pwbsd_pkg::TimeWidth;
  localparam int unsigned SW = pwbsd_pkg::SlotWidth;

  logic [TW-1:0]                     rise_q, rise_d;
  logic [TW-1:0]                     sync_q, sync_d;
  logic [pwbsd_pkg::IndexWidth-1:0]  idx_q, idx_d;
  logic [pwbsd_pkg::ByteWidth-1:0]   asm_q, asm_d;
  logic                              tog_q, tog_d;

  logic [TW-1:0]                     width_w, elapsed_w, late_d_w;
  logic                              is_sync, is_glitch, in_slot, late;
  logic [SW-1:0]                     lo_w, hi_w, in_off_w, out_off_w;
  logic [pwbsd_pkg::IndexWidth-1:0]  slot_w;
  logic [pwbsd_pkg::ByteWidth-1:0]   bit_mask;
  logic                              emit;

  assign width_w   = time_us_i - rise_q;
  assign elapsed_w = time_us_i - sync_q;
  assign is_sync   = (width_w < {16'd0, cfg_i.sync_high}) && (width_w > {16'd0, cfg_i.sync_low});
  assign is_glitch = width_w < {16'd0, cfg_i.glitch};

  assign lo_w     = pwbsd_pkg::SlotLo[idx_q];
  assign hi_w     = pwbsd_pkg::SlotHi[idx_q];
  assign in_slot  = (elapsed_w > {18'd0, lo_w}) && (elapsed_w < {18'd0, hi_w});
  assign in_off_w = elapsed_w[SW-1:0] - lo_w;

  assign late_d_w = elapsed_w - pwbsd_pkg::SlotOffset;
  assign late     = late_d_w >= pwbsd_pkg::LateLimit;

  always_comb begin
    slot_w = '0;
    for (int k = 1; k < 7; k++) begin
      if (late_d_w[SW-1:0] >= pwbsd_pkg::SlotBase[k]) begin
        slot_w = 3'(k);
      end
    end
  end

  assign out_off_w = late_d_w[SW-1:0] - pwbsd_pkg::SlotBase[slot_w];
  assign bit_mask  = 8'd1 << (pwbsd_pkg::LastBit - idx_q);

  always_comb begin
    rise_d = rise_q;
    sync_d = sync_q;
    idx_d  = idx_q;
    asm_d  = asm_q;
    tog_d  = tog_q;
    emit   = 1'b0;
    if (line_level_i) begin
      rise_d = time_us_i;
    end else if (is_sync) begin
      idx_d  = '0;
      asm_d  = '0;
      sync_d = time_us_i;
    end else if (!is_glitch) begin
      if (in_slot) begin
        if ({2'd0, in_off_w} > cfg_i.one_thr) begin
          asm_d = asm_q | bit_mask;
        end
        if (idx_q == pwbsd_pkg::LastBit) begin
          emit  = 1'b1;
          tog_d = ~tog_q;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end else if (late) begin
        emit  = 1'b1;
        tog_d = ~tog_q;
        idx_d = '0;
      end else begin
        if ({2'd0, out_off_w} > cfg_i.one_thr) begin
          asm_d = asm_q | bit_mask;
        end
        idx_d = slot_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= '0;
      sync_q <= '0;
      idx_q  <= '0;
      asm_q  <= '0;
      tog_q  <= 1'b0;
    end else if (step_i) begin
      rise_q <= rise_d;
      sync_q <= sync_d;
      idx_q  <= idx_d;
      asm_q  <= asm_d;
      tog_q  <= tog_d;
    end
  end

  assign res_o.emit        = emit;
  assign res_o.byte_value  = asm_d;
  assign res_o.buffer_slot = tog_q;

endmodule

`default_nettype wire

### rtl/core/pulse_width_bit_slot_decoder.sv
// Pulse width bit slot decoder top level: input register, decode stage, output register.
// A byte's last edge word passes the input register, then the byte the output register.
// Throughput: one edge word per cycle, set by the single decode pass on the framing state.
// The input stalls only while a byte waits in the output register and another is due.
// Reset: asynchronous active low; configuration returns to 470/530/100/600, state to zero.
`default_nettype none

module pulse_width_bit_slot_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_addr_i,
  input  wire logic [pwbsd_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic                              line_level_i,
  input  wire logic [pwbsd_pkg::TimeWidth-1:0]   time_us_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [pwbsd_pkg::ByteWidth-1:0]   byte_value_o,
  output      logic                              buffer_slot_o
);

  pwbsd_pkg::cfg_t     cfg;
  pwbsd_pkg::dec_res_t res;

  logic                            s1_valid_q;
  logic                            s1_level_q;
  logic [pwbsd_pkg::TimeWidth-1:0] s1_time_q;
  logic                            s1_go;
  logic                            out_valid_q;
  logic [pwbsd_pkg::ByteWidth-1:0] out_byte_q;
  logic                            out_slot_q;

  pwbsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pwbsd_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (s1_go),
    .line_level_i (s1_level_q),
    .time_us_i    (s1_time_q),
    .res_o        (res)
  );

  assign s1_go      = s1_valid_q && (!res.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_level_q <= line_level_i;
      s1_time_q  <= time_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res.emit) begin
      out_byte_q <= res.byte_value;
      out_slot_q <= res.buffer_slot;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_value_o  = out_byte_q;
  assign buffer_slot_o = out_slot_q;

endmodule

`default_nettype wire

### rtl/core/pwbsd_checker.sv
// Port-level checks for the pulse width bit slot decoder, bound to the top level.
// Depends on pwbsd_pkg and pulse_width_bit_slot_decoder.
`default_nettype none

module pwbsd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              line_level_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [pwbsd_pkg::ByteWidth-1:0]   byte_value_o,
  input wire logic                              buffer_slot_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_value_o) && $stable(buffer_slot_o))
    else $error("output word changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

  a_out_from_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && !line_level_i, 2))
    else $error("output word without a falling edge word two cycles earlier");

endmodule

bind pulse_width_bit_slot_decoder pwbsd_checker u_pwbsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .line_level_i  (line_level_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .byte_value_o  (byte_value_o),
  .buffer_slot_o (buffer_slot_o)
);

`default_nettype wire

### tb/pwbsd_byte_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the pulse width bit slot decoder: tracks framing state per edge word
// and checks each decoded byte against the oldest one predicted.
// Depends on pwbsd_pkg for register indexes and reset values.

class pwbsd_byte_scoreboard;
  localparam logic [31:0] SlotStartUs = 32'd500;
  localparam logic [31:0] SlotUs      = 32'd1000;
  localparam int          ShownFails  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       slot;
  } byte_exp_t;

  logic [15:0] sync_low, sync_high, glitch, one_thr;
  logic [31:0] rise_t, sync_t;
  logic [2:0]  bit_idx;
  logic [7:0]  asm_byte;
  logic        slot_tgl;
  byte_exp_t   byte_q[$];
  int unsigned fail_cnt, byte_cnt;

  function new();
    sync_low  = pwbsd_pkg::SyncLowReset;
    sync_high = pwbsd_pkg::SyncHighReset;
    glitch    = pwbsd_pkg::GlitchReset;
    one_thr   = pwbsd_pkg::OneThrReset;
    rise_t    = '0;
    sync_t    = '0;
    bit_idx   = '0;
    asm_byte  = '0;
    slot_tgl  = 1'b0;
    fail_cnt  = 0;
    byte_cnt  = 0;
  endfunction

  function void write_reg(pwbsd_pkg::cfg_reg_e idx, logic [15:0] value);
    case (idx)
      pwbsd_pkg::CfgSyncLow:  sync_low  = value;
      pwbsd_pkg::CfgSyncHigh: sync_high = value;
      pwbsd_pkg::CfgGlitch:   glitch    = value;
      pwbsd_pkg::CfgOneThr:   one_thr   = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return byte_q.size();
  endfunction

  function void emit_byte();
    byte_q.push_back({asm_byte, slot_tgl});
    slot_tgl = ~slot_tgl;
    bit_idx  = '0;
  endfunction

  function void note_edge(logic level, logic [31:0] t);
    logic [31:0] width, elapsed, lo, hi, timed_slot, offset;
    if (level) begin
      rise_t = t;
      return;
    end
    width   = t - rise_t;
    elapsed = t - sync_t;
    if (width < {16'd0, sync_high} && width > {16'd0, sync_low}) begin
      bit_idx  = '0;
      asm_byte = '0;
      sync_t   = t;
      return;
    end
    if (width < {16'd0, glitch}) return;
    lo = SlotStartUs + SlotUs * {29'd0, bit_idx};
    hi = lo + SlotUs;
    if (elapsed > lo && elapsed < hi) begin
      if (elapsed - lo > {16'd0, one_thr}) asm_byte[3'd7 - bit_idx] = 1'b1;
      if (bit_idx == 3'd7) emit_byte();
      else bit_idx = bit_idx + 3'd1;
      return;
    end
    // out of its slot: emit the byte when late, else resync the index to the timed slot
    timed_slot = (elapsed - SlotStartUs) / SlotUs;
    if (timed_slot >= 32'd7) begin
      emit_byte();
      return;
    end
    offset = elapsed - SlotStartUs - SlotUs * timed_slot;
    if (offset > {16'd0, one_thr}) asm_byte[3'd7 - bit_idx] = 1'b1;
    bit_idx = timed_slot[2:0];
  endfunction

  function void check_byte(logic [7:0] value, logic slot);
    byte_exp_t want;
    byte_cnt++;
    if (byte_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= ShownFails)
        $display("%0t: byte %02h slot %0d with no byte pending", $time, value, slot);
      return;
    end
    want = byte_q.pop_front();
    if (value !== want.value || slot !== want.slot) begin
      fail_cnt++;
      if (fail_cnt <= ShownFails)
        $display("%0t: got byte %02h slot %0d, expected byte %02h slot %0d",
                 $time, value, slot, want.value, want.slot);
    end
  endfunction
endclass

### tb/tb_pulse_width_bit_slot_decoder.sv
`timescale 1ns / 100ps
// Top testbench for pulse_width_bit_slot_decoder: directed and random edge words over
// several register settings with idling on both sides. Depends on pwbsd_pkg and
// pwbsd_byte_scoreboard.

module tb_pulse_width_bit_slot_decoder;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 9;
  localparam int NumPhases     = 6;
  localparam int WordsPerPhase = 330;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 400000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_addr_i   = '0;
  logic [15:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        line_level_i = 1'b0;
  logic [31:0] time_us_i    = '0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  byte_value_o;
  logic        buffer_slot_o;

  logic [15:0] phase_cfg [NumPhases][4] = '{
    '{16'd470,   16'd530,   16'd100,   16'd600},
    '{16'd0,     16'd65535, 16'd0,     16'd0},
    '{16'd65535, 16'd0,     16'd65535, 16'd65535},
    '{16'd200,   16'd900,   16'd50,    16'd999},
    '{16'd10,    16'd12,    16'd5,     16'd300},
    '{16'd470,   16'd530,   16'd100,   16'd600}
  };

  pwbsd_byte_scoreboard sb;
  logic [15:0] cur_cfg [4];
  logic [31:0] now_t;
  int          words_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          cycle_cnt;
  bit          hold_req;

  pulse_width_bit_slot_decoder i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .line_level_i,
    .time_us_i,
    .out_valid_o,
    .out_ready_i,
    .byte_value_o,
    .buffer_slot_o
  );

  always #ClkHalf clk_i = ~clk_i;

  task automatic send_edge(input logic level, input logic [31:0] t);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    line_level_i <= level;
    time_us_i    <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_edge(level, t);
    words_sent++;
  endtask

  task automatic pulse(input logic [31:0] fall_t, input int width);
    send_edge(1'b1, fall_t - width);
    send_edge(1'b0, fall_t);
  endtask

  function automatic int sync_width();
    int lw, hw;
    lw = cur_cfg[pwbsd_pkg::CfgSyncLow];
    hw = cur_cfg[pwbsd_pkg::CfgSyncHigh];
    if (hw - lw >= 2) return $urandom_range(lw + 1, hw - 1);
    return 500;
  endfunction

  function automatic int data_width();
    int g, lw, hw;
    g  = cur_cfg[pwbsd_pkg::CfgGlitch];
    lw = cur_cfg[pwbsd_pkg::CfgSyncLow];
    hw = cur_cfg[pwbsd_pkg::CfgSyncHigh];
    if (g <= lw && $urandom_range(0, 1) == 1) return $urandom_range(g, lw);
    return ((hw > g) ? hw : g) + $urandom_range(0, 300);
  endfunction

  function automatic int slot_offset();
    int v;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 999);
    v = cur_cfg[pwbsd_pkg::CfgOneThr] + $urandom_range(0, 1);
    if (v < 1) v = 1;
    if (v > 999) v = 999;
    return v;
  endfunction

  task automatic send_frame(input bit broken);
    logic [31:0] s;
    int nbits, k, e, pick;
    s = now_t + $urandom_range(600, 20000);
    pulse(s, sync_width());
    nbits = broken ? $urandom_range(1, 7) : 8;
    for (k = 0; k < nbits; k++) begin
      pick = $urandom_range(0, 99);
      if (broken) e = $urandom_range(0, 9000);
      else if (pick < 86) e = 500 + 1000 * k + slot_offset();
      else if (pick < 90) e = 500 + 1000 * (k + $urandom_range(0, 1));
      else if (pick < 94) e = 500 + 1000 * (k + $urandom_range(1, 3)) + slot_offset();
      else if (pick < 97) e = $urandom_range(0, 499);
      else begin
        if (cur_cfg[pwbsd_pkg::CfgGlitch] != 0)
          pulse(s + 500 + 1000 * k + 300,
                $urandom_range(0, cur_cfg[pwbsd_pkg::CfgGlitch] - 1));
        e = 500 + 1000 * k + slot_offset();
      end
      pulse(s + e, data_width());
    end
    now_t = s + 10000;
  endtask

  task automatic send_noise();
    int n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      now_t = now_t + $urandom_range(0, 3000);
      send_edge($urandom_range(0, 1), ($urandom_range(0, 3) == 0) ? $urandom : now_t);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(input int p);
    int r;
    for (r = 0; r < 4; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= pwbsd_pkg::cfg_reg_e'(r);
      cfg_wdata_i <= phase_cfg[p][r];
      cur_cfg[r]   = phase_cfg[p][r];
      sb.write_reg(pwbsd_pkg::cfg_reg_e'(r), phase_cfg[p][r]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_byte(byte_value_o, buffer_slot_o);
  end

  initial begin : rx_side
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d bytes pending", cycle_cnt, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int p, r, target;
    sb          = new();
    words_sent  = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    now_t       = $urandom;
    for (r = 0; r < 4; r++) cur_cfg[r] = phase_cfg[0][r];
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        apply_config(p);
      end
      case (p / 2)
        0: begin tx_idle_pct = 21; rx_idle_pct = 83; end
        1: begin tx_idle_pct = 83; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (p == 1 || p == 4) hold_req = ~hold_req;

      if (p == 0) begin
        // sync pulse straddling the timestamp wrap
        send_edge(1'b1, 32'hFFFF_FFFF);
        send_edge(1'b0, 32'd499);
        pulse(32'd499 + 1101, 200);
        pulse(32'd499 + 2100, 200);
        pulse(32'd499 + 2300, 99);
        pulse(32'd499 + 3499, 100);
        pulse(32'd499 + 4500, 470);
        pulse(32'd499 + 4500, 530);
        pulse(32'd499 + 7200, 300);
        pulse(32'd499 + 6501, 300);
        pulse(32'd499 + 8300, 300);
        // late bit without resync: byte is sent again uncleared
        pulse(32'd499 + 20000, 300);
        pulse(32'd499 + 30000, 500);
        pulse(32'd499 + 30200, 150);
        pulse(32'd499 + 37505, 150);
        now_t = 32'd499 + 40000;
      end

      target = words_sent + WordsPerPhase;
      while (words_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_frame(1'b0);
        else if (r < 85) send_frame(1'b1);
        else send_noise();
      end
    end
    drain();

    $display("Sent %0d edge words over %0d register settings, stalls on both sides;",
             words_sent, NumPhases);
    $display("compared %0d decoded bytes, %0d failures.", sb.byte_cnt, sb.fail_cnt);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### pulse_width_bit_slot_decoder.f
rtl/core/pwbsd_pkg.sv
rtl/core/pwbsd_cfg_regs.sv
rtl/core/pwbsd_decode.sv
rtl/core/pulse_width_bit_slot_decoder.sv
rtl/core/pwbsd_checker.sv
tb/pwbsd_byte_scoreboard.sv
tb/tb_pulse_width_bit_slot_decoder.sv
